FILE: rtl/fbmc_pkg.sv
// ============================================================================
// fbmc_pkg - shared definitions for the flash backup memory controller
// Store geometry, flash command codes, ID bytes and the control structs that
// pass between the command decoder and the top level.
// ============================================================================
package fbmc_pkg;

  // Store geometry
  localparam int BackupBytesDef = 131072;
  localparam int BankBytes      = 65536;
  localparam int SectorBytes    = 4096;
  localparam int BankW          = 16;          // bits of offset inside a bank
  localparam int SumW           = BankW + 1;   // bank offset plus bank bit
  localparam int SecW           = 12;          // log2 of the sector size

  // Access kinds
  localparam logic KindRead  = 1'b0;
  localparam logic KindWrite = 1'b1;

  // Backup kind register
  localparam logic BkFlash = 1'b0;
  localparam logic BkSram  = 1'b1;

  // Fixed command offsets
  localparam logic [24:0] OfsUnlockA = 25'h0005555;
  localparam logic [24:0] OfsUnlockB = 25'h0002AAA;
  localparam logic [24:0] OfsMaker   = 25'h0000000;
  localparam logic [24:0] OfsDevice  = 25'h0000001;
  localparam logic [24:0] OfsBankSel = 25'h0000000;

  // Full three-byte command words, and the one-byte sector erase code
  localparam logic [23:0] CmdIdEntry  = 24'hAA5590;
  localparam logic [23:0] CmdReset    = 24'hAA55F0;
  localparam logic [23:0] CmdErasePrep = 24'hAA5580;
  localparam logic [23:0] CmdProgram  = 24'hAA55A0;
  localparam logic [23:0] CmdBankSel  = 24'hAA55B0;
  localparam logic [23:0] CmdChipErase = 24'hAA5510;
  localparam logic [7:0]  CmdSectorErase = 8'h30;

  // ID bytes
  localparam logic [7:0] MakerId  = 8'hC2;
  localparam logic [7:0] DeviceId = 8'h09;

  // Fill values
  localparam logic [7:0] ClearByte = 8'h00;
  localparam logic [7:0] EraseByte = 8'hFF;

  // Flash mode, one-hot
  typedef enum logic [4:0] {
    MODE_NORMAL  = 5'b00001,
    MODE_ID      = 5'b00010,
    MODE_ERASE   = 5'b00100,
    MODE_PROGRAM = 5'b01000,
    MODE_BANK    = 5'b10000
  } mode_e;

  // Store actions requested by one flash write
  typedef struct packed {
    logic prog;     // store the written byte
    logic sector;   // erase one sector
    logic chip;     // erase the whole store
  } fbmc_act_t;

  // Flash state seen by the data path
  typedef struct packed {
    logic id_mode;
    logic bank;
  } fbmc_stat_t;

endpackage

FILE: rtl/fbmc_ram.sv
// ============================================================================
// fbmc_ram - generic single-port synchronous RAM
// One read or one write per cycle, read data registered.
// ============================================================================
module fbmc_ram #(
  parameter int Width = 8,
  parameter int Depth = 131072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fbmc_cmd.sv
// ============================================================================
// fbmc_cmd - flash command state machine
// Tracks the unlock sequence, flash mode and bank, and flags store actions.
// ============================================================================
module fbmc_cmd (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  logic [24:0]          addr_i,
  input  logic [7:0]           data_i,
  output fbmc_pkg::fbmc_act_t  act_o,
  output fbmc_pkg::fbmc_stat_t stat_o
);
  import fbmc_pkg::*;

  mode_e       mode_q, mode_d, mode_eff;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] hi_q, hi_d;       // first two unlock bytes
  logic        bank_q, bank_d;
  fbmc_act_t   act;

  always_comb begin
    act      = '0;
    mode_eff = mode_q;
    if (mode_q == MODE_PROGRAM) begin
      act.prog = 1'b1;
      mode_eff = MODE_NORMAL;
    end
    mode_d  = mode_eff;
    phase_d = phase_q;
    hi_d    = hi_q;
    bank_d  = bank_q;

    if (mode_eff == MODE_BANK && addr_i == OfsBankSel) begin
      bank_d = data_i[0];
      mode_d = MODE_NORMAL;
    end else if (phase_q == 2'd0 && addr_i == OfsUnlockA) begin
      hi_d    = {data_i, 8'h00};
      phase_d = 2'd1;
    end else if (phase_q == 2'd1 && addr_i == OfsUnlockB) begin
      hi_d    = {hi_q[15:8], data_i};
      phase_d = 2'd2;
    end else if (phase_q == 2'd2 && addr_i == OfsUnlockA) begin
      case ({hi_q, data_i})
        CmdIdEntry:   mode_d = MODE_ID;
        CmdReset:     mode_d = MODE_NORMAL;
        CmdErasePrep: mode_d = MODE_ERASE;
        CmdProgram:   mode_d = MODE_PROGRAM;
        CmdBankSel:   mode_d = MODE_BANK;
        CmdChipErase: begin
          if (mode_eff == MODE_ERASE) begin
            act.chip = 1'b1;
            mode_d   = MODE_NORMAL;
          end
        end
        default: ;
      endcase
      hi_d    = '0;
      phase_d = 2'd0;
    end else if (mode_eff == MODE_ERASE && phase_q == 2'd2 && data_i == CmdSectorErase) begin
      act.sector = 1'b1;
      hi_d       = '0;
      phase_d    = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      phase_q <= 2'd0;
      hi_q    <= '0;
      bank_q  <= 1'b0;
    end else if (wr_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      hi_q    <= hi_d;
      bank_q  <= bank_d;
    end
  end

  assign act_o          = wr_i ? act : '0;
  assign stat_o.id_mode = (mode_q == MODE_ID);
  assign stat_o.bank    = bank_q;

`ifndef SYNTHESIS
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({act_o.prog, act_o.sector, act_o.chip}))
    else $error("more than one store action from one write");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("unlock phase out of range");

  a_chip_to_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_o.chip |=> (mode_q == MODE_NORMAL && phase_q == 2'd0))
    else $error("chip erase did not return to normal mode");

  a_sector_keeps_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_o.sector |=> (mode_q == MODE_ERASE && phase_q == 2'd0))
    else $error("sector erase left wrong mode or phase");
`endif

endmodule

FILE: rtl/flash_backup_memory_controller_unit.sv
// ============================================================================
// flash_backup_memory_controller_unit - byte-wide save memory, flash or SRAM
// Byte store behind a flash command state machine, with erase sequencer.
// ============================================================================
// Use:
//   Command channel: present kind_i, address_i and write_data_i with start;
//   the transfer happens at the edge where start is high and busy is low.
//   Every transfer gives one result: done_o pulses for exactly one cycle,
//   the cycle after the transfer, with read_data_o (0 for writes). The
//   receiver cannot hold results off, so done_o is never stretched.
//   Ordinary reads and writes may follow back to back; the single RAM
//   port does the access at the transfer edge and the registered read data
//   is shown in the next cycle.
//   A sector erase holds busy while it erases up to 4096 bytes, a chip erase
//   while it erases the store, one byte written per cycle through the RAM port.
//   Reset clears the control state and then runs a clearing pass that writes
//   zero to every byte; busy stays high meanwhile. Configuration
//   (cfg_valid_i/cfg_data_i) is always taken and
//   must only change while the block is idle.
// ============================================================================
module flash_backup_memory_controller_unit #(
  parameter int BACKUP_BYTES = fbmc_pkg::BackupBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [24:0] address_i,
  input  logic [7:0]  write_data_i,
  // result
  output logic        done_o,
  output logic [7:0]  read_data_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import fbmc_pkg::*;

  localparam int IdxW = $clog2(BACKUP_BYTES);
  localparam logic [SumW:0]   BackupSz = (SumW+1)'(BACKUP_BYTES);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(BACKUP_BYTES - 1);
  localparam logic [SumW:0]   SecSpan  = (SumW+1)'(SectorBytes - 1);

  // Sequencer: idle serves accesses, fill sweeps the store
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [IdxW-1:0] end_q, end_d;
  logic [7:0]      fill_q, fill_d;
  logic            backup_kind_q;
  logic            done_q;
  logic            res_ram_q;
  logic [7:0]      res_byte_q;

  logic            accept;
  logic            is_flash;
  logic            use_bank;
  logic [SumW-1:0] sum;
  logic [SumW:0]   red;
  logic [IdxW-1:0] idx;
  logic [SumW:0]   sec_base;
  logic [SumW:0]   sec_last;
  logic [IdxW-1:0] sec_end;
  logic [7:0]      id_byte;

  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  fbmc_act_t       act;
  fbmc_stat_t      stat;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign is_flash    = (backup_kind_q == BkFlash);
  assign cfg_ready_o = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backup_kind_q <= BkFlash;
    end else if (cfg_valid_i && cfg_ready_o) begin
      backup_kind_q <= cfg_data_i;
    end
  end

  // Store index: bank offset plus selected bank, folded once into the store
  // (the sum is below twice the store size when BACKUP_BYTES >= 65536).
  assign use_bank = is_flash && stat.bank;
  assign sum      = {1'b0, address_i[BankW-1:0]} + {use_bank, BankW'(0)};
  assign red      = ({1'b0, sum} >= BackupSz) ? ({1'b0, sum} - BackupSz) : {1'b0, sum};
  assign idx      = red[IdxW-1:0];

  // Sector window, cut short at the end of the store
  assign sec_base = {red[SumW:SecW], SecW'(0)};
  assign sec_last = sec_base + SecSpan;
  assign sec_end  = (sec_last >= BackupSz) ? LastIdx : sec_last[IdxW-1:0];

  // ID bytes
  always_comb begin
    case (address_i)
      OfsMaker:  id_byte = MakerId;
      OfsDevice: id_byte = DeviceId;
      default:   id_byte = 8'h00;
    endcase
  end

  fbmc_cmd u_cmd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (accept && kind_i == KindWrite && is_flash),
    .addr_i (address_i),
    .data_i (write_data_i),
    .act_o  (act),
    .stat_o (stat)
  );

  // Sequencer and RAM port steering
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    fill_d    = fill_q;
    ram_we    = 1'b0;
    ram_addr  = idx;
    ram_wdata = write_data_i;
    case (state_q)
      ST_IDLE: begin
        if (accept && kind_i == KindWrite) begin
          ram_we = !is_flash || act.prog;
          if (act.chip) begin
            state_d = ST_FILL;
            ptr_d   = '0;
            end_d   = LastIdx;
            fill_d  = EraseByte;
          end else if (act.sector) begin
            state_d = ST_FILL;
            ptr_d   = sec_base[IdxW-1:0];
            end_d   = sec_end;
            fill_d  = EraseByte;
          end
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_addr  = ptr_q;
        ram_wdata = fill_q;
        if (ptr_q == end_q) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Reset starts a clearing pass over the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      ptr_q   <= '0;
      end_q   <= LastIdx;
      fill_q  <= ClearByte;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      end_q   <= end_d;
      fill_q  <= fill_d;
    end
  end

  // Result: RAM data for store reads, otherwise a held byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      res_ram_q <= 1'b0;
    end else begin
      done_q    <= accept;
      res_ram_q <= accept && kind_i == KindRead && !(is_flash && stat.id_mode);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_byte_q <= (kind_i == KindRead && is_flash && stat.id_mode) ? id_byte : 8'h00;
    end
  end

  fbmc_ram #(
    .Width (8),
    .Depth (BACKUP_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign done_o      = done_q;
  assign read_data_o = res_ram_q ? ram_rdata : res_byte_q;

`ifndef SYNTHESIS
  a_done_follows_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without a preceding transfer");

  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (ptr_q <= end_q))
    else $error("fill pointer ran past its end");

  a_ram_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_FILL) || (accept && kind_i == KindWrite)))
    else $error("store written outside a fill or a write transfer");

  a_ram_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ram_q |-> (done_o && $past(!ram_we)))
    else $error("store read result without a read access");
`endif

endmodule
